// ----- rtl/rrapm_pkg.sv -----
// shared constants for the round-robin adc period meter
// channel count, field widths, register indexes and reset values
// no dependencies
`default_nettype none

package rrapm_pkg;

  localparam int unsigned NUM_CHANNELS    = 8;
  localparam int unsigned MONITOR_CHANNEL = 3;

  // channel index width; at least one bit
  localparam int unsigned CH_W = (NUM_CHANNELS > 2) ? $clog2(NUM_CHANNELS) : 1;
  localparam bit          MON_EN = (MONITOR_CHANNEL < NUM_CHANNELS);

  localparam int unsigned SMP_W  = 12;
  localparam int unsigned TICK_W = 32;
  localparam int unsigned SCL_W  = 8;
  localparam int unsigned WORD_W = 16;
  localparam int unsigned CHO_W  = 3;
  localparam int unsigned CFGA_W = 2;
  localparam int unsigned CFGD_W = 12;

  // configuration register indexes
  localparam logic [CFGA_W-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [CFGA_W-1:0] REG_SCALE     = 2'd1;
  localparam logic [CFGA_W-1:0] REG_RUN       = 2'd2;

  localparam logic [SMP_W-1:0] THRESHOLD_RST = 12'd2000;
  localparam logic [SCL_W-1:0] SCALE_RST     = 8'd26;

  // item kinds
  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_CONV = 1'b1;

endpackage

`default_nettype wire

// ----- rtl/round_robin_adc_period_meter.sv -----
// round-robin adc sampler with per-channel falling-edge period measurement
// per-channel sample and edge-time stores are small synchronous memories
// depends on rrapm_pkg
`default_nettype none

// usage
// - input channel (in_valid_i / in_ready_o): one item per handshake, either a
//   timer tick (kind_i = 0) or a received conversion word (kind_i = 1, rx_word_i)
// - output channel (out_valid_o / out_ready_i): exactly one result item per
//   input item, in order
// - config channel (cfg_valid_i / cfg_ready_o): index 0 threshold, 1 period
//   scale, 2 run enable; always ready; the user must write only while the block
//   is idle; the block itself does not enforce it
// - path: memory read, edge detect and writeback, the 8-bit by 32-bit period
//   multiply in its own stage after the subtract, into the output register
// - throughput: one item per cycle while results are taken; the three stages
//   move independently so bubbles close up and the input keeps being taken
//   while a result waits
// - reset clears the tick counter, channel pointer, busy flag and the valid
//   bits of both stores, so every channel reads back as zero until written
// - when the receiver stalls, results pile up in the stages; once all three
//   are full in_ready_o drops until the output is taken
module round_robin_adc_period_meter (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // config write port
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [rrapm_pkg::CFGA_W-1:0]  cfg_index_i,
  input  wire logic [rrapm_pkg::CFGD_W-1:0]  cfg_data_i,
  // input items
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic                          kind_i,
  input  wire logic [rrapm_pkg::WORD_W-1:0]  rx_word_i,
  // result items
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic                               start_conversion_o,
  output logic [rrapm_pkg::CHO_W-1:0]        request_channel_o,
  output logic                               sample_valid_o,
  output logic [rrapm_pkg::CHO_W-1:0]        sample_channel_o,
  output logic [rrapm_pkg::SMP_W-1:0]        sample_value_o,
  output logic                               falling_edge_o,
  output logic [rrapm_pkg::TICK_W-1:0]       period_us_o,
  output logic                               monitor_high_o
);

  localparam int unsigned CH_W   = rrapm_pkg::CH_W;
  localparam int unsigned SMP_W  = rrapm_pkg::SMP_W;
  localparam int unsigned TICK_W = rrapm_pkg::TICK_W;
  localparam int unsigned SCL_W  = rrapm_pkg::SCL_W;
  localparam int unsigned CHO_W  = rrapm_pkg::CHO_W;
  localparam int unsigned NCH    = rrapm_pkg::NUM_CHANNELS;
  localparam logic [CH_W-1:0] LAST_CH = CH_W'(NCH - 1);
  localparam logic [CH_W-1:0] MON_CH  = CH_W'(rrapm_pkg::MONITOR_CHANNEL);

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [SMP_W-1:0] threshold_q;
  logic [SCL_W-1:0] scale_q;
  logic             run_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= rrapm_pkg::THRESHOLD_RST;
      scale_q     <= rrapm_pkg::SCALE_RST;
      run_q       <= 1'b1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        rrapm_pkg::REG_THRESHOLD: threshold_q <= cfg_data_i[SMP_W-1:0];
        rrapm_pkg::REG_SCALE:     scale_q     <= cfg_data_i[SCL_W-1:0];
        rrapm_pkg::REG_RUN:       run_q       <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // stage enables: each stage loads when it is empty or its contents move on
  // ---------------------------------------------------------------------------
  logic s1_valid_q, s2_valid_q, out_valid_q;
  logic out_en, s2_en, s1_en, in_acc;

  assign out_en     = !out_valid_q || out_ready_i;
  assign s2_en      = !s2_valid_q || out_en;
  assign s1_en      = !s1_valid_q || s2_en;
  assign in_ready_o = s1_en;
  assign in_acc     = in_valid_i && s1_en;

  // ---------------------------------------------------------------------------
  // stage 0: tick counter, busy flag and channel pointer update on acceptance
  // ---------------------------------------------------------------------------
  logic [TICK_W-1:0] tick_q;
  logic [CH_W-1:0]   ptr_q;
  logic              busy_q;
  logic              is_conv, is_tick_run, start_req;
  logic [CH_W-1:0]   prev_ch;
  logic [TICK_W-1:0] tick_d;

  assign is_conv     = (kind_i == rrapm_pkg::KIND_CONV);
  assign is_tick_run = (kind_i == rrapm_pkg::KIND_TICK) && run_q;
  assign start_req   = is_tick_run && !busy_q;
  // the converter answers one command late: credit the channel before the pointer
  assign prev_ch     = (ptr_q == '0) ? LAST_CH : (ptr_q - CH_W'(1));
  assign tick_d      = is_tick_run ? (tick_q + TICK_W'(1)) : tick_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q <= '0;
      ptr_q  <= '0;
      busy_q <= 1'b0;
    end else if (in_acc) begin
      tick_q <= tick_d;
      if (is_conv) begin
        busy_q <= 1'b0;
        ptr_q  <= (ptr_q == LAST_CH) ? '0 : (ptr_q + CH_W'(1));
      end else if (start_req) begin
        busy_q <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // per-channel stores, read at acceptance and written back as stage 1 leaves
  // consecutive conversions always hit neighbouring channels, so a read never
  // meets a pending write to the same entry
  // ---------------------------------------------------------------------------
  logic [SMP_W-1:0]  smp_mem [NCH];
  logic [TICK_W-1:0] edg_mem [NCH];
  logic [NCH-1:0]    smp_vld_q, edg_vld_q;
  logic [SMP_W-1:0]  smp_rd_q;
  logic [TICK_W-1:0] edg_rd_q;
  logic              smp_rd_vld_q, edg_rd_vld_q;

  // stage 1 payload
  logic              s1_conv_q, s1_start_q;
  logic [CHO_W-1:0]  s1_req_q;
  logic [CH_W-1:0]   s1_idx_q;
  logic [SMP_W-1:0]  s1_smp_q;
  logic [TICK_W-1:0] s1_tick_q;

  logic              s1_leave, smp_we, edg_we;
  logic [SMP_W-1:0]  prev_smp, mon_smp_q, mon_smp_d;
  logic [TICK_W-1:0] last_edge, tick_diff;
  logic              prev_high, cur_high, s1_fall, s1_mon;

  assign s1_leave  = s1_valid_q && s2_en;
  assign prev_smp  = smp_rd_vld_q ? smp_rd_q : '0;
  assign last_edge = edg_rd_vld_q ? edg_rd_q : '0;
  assign prev_high = prev_smp > threshold_q;
  assign cur_high  = s1_smp_q > threshold_q;
  assign s1_fall   = s1_conv_q && prev_high && !cur_high;
  assign tick_diff = s1_tick_q - last_edge;
  assign smp_we    = s1_leave && s1_conv_q;
  assign edg_we    = s1_leave && s1_fall;

  // monitor flag reflects the store after this item's update
  assign mon_smp_d = (s1_conv_q && (s1_idx_q == MON_CH)) ? s1_smp_q : mon_smp_q;
  assign s1_mon    = rrapm_pkg::MON_EN && (mon_smp_d > threshold_q);

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      smp_rd_q <= smp_mem[prev_ch];
      edg_rd_q <= edg_mem[prev_ch];
    end
    if (smp_we) begin
      smp_mem[s1_idx_q] <= s1_smp_q;
    end
    if (edg_we) begin
      edg_mem[s1_idx_q] <= s1_tick_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smp_vld_q    <= '0;
      edg_vld_q    <= '0;
      smp_rd_vld_q <= 1'b0;
      edg_rd_vld_q <= 1'b0;
      mon_smp_q    <= '0;
    end else begin
      if (in_acc) begin
        smp_rd_vld_q <= smp_vld_q[prev_ch];
        edg_rd_vld_q <= edg_vld_q[prev_ch];
      end
      if (smp_we) begin
        smp_vld_q[s1_idx_q] <= 1'b1;
      end
      if (edg_we) begin
        edg_vld_q[s1_idx_q] <= 1'b1;
      end
      if (s1_leave) begin
        mon_smp_q <= mon_smp_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_conv_q  <= is_conv;
      s1_start_q <= start_req;
      s1_req_q   <= start_req ? CHO_W'(ptr_q) : '0;
      s1_idx_q   <= prev_ch;
      s1_smp_q   <= rx_word_i[rrapm_pkg::WORD_W-1:4];
      s1_tick_q  <= tick_q;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 2: edge result and raw period, then scaling into the output register
  // ---------------------------------------------------------------------------
  logic              s2_start_q, s2_conv_q, s2_fall_q, s2_mon_q;
  logic [CHO_W-1:0]  s2_req_q, s2_ch_q;
  logic [SMP_W-1:0]  s2_smp_q;
  logic [TICK_W-1:0] s2_diff_q, period;

  always_ff @(posedge clk_i) begin
    if (s1_leave) begin
      s2_start_q <= s1_start_q;
      s2_req_q   <= s1_req_q;
      s2_conv_q  <= s1_conv_q;
      s2_ch_q    <= s1_conv_q ? CHO_W'(s1_idx_q) : '0;
      s2_smp_q   <= s1_conv_q ? s1_smp_q : '0;
      s2_fall_q  <= s1_fall;
      s2_diff_q  <= tick_diff;
      s2_mon_q   <= s1_mon;
    end
  end

  // wraps at 32 bits
  assign period = s2_diff_q * TICK_W'(scale_q);

  logic              o_start_q, o_conv_q, o_fall_q, o_mon_q;
  logic [CHO_W-1:0]  o_req_q, o_ch_q;
  logic [SMP_W-1:0]  o_smp_q;
  logic [TICK_W-1:0] o_period_q;

  always_ff @(posedge clk_i) begin
    if (s2_valid_q && out_en) begin
      o_start_q  <= s2_start_q;
      o_req_q    <= s2_req_q;
      o_conv_q   <= s2_conv_q;
      o_ch_q     <= s2_ch_q;
      o_smp_q    <= s2_smp_q;
      o_fall_q   <= s2_fall_q;
      o_period_q <= s2_fall_q ? period : '0;
      o_mon_q    <= s2_mon_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_en) begin
        s1_valid_q <= in_valid_i;
      end
      if (s2_en) begin
        s2_valid_q <= s1_valid_q;
      end
      if (out_en) begin
        out_valid_q <= s2_valid_q;
      end
    end
  end

  assign out_valid_o        = out_valid_q;
  assign start_conversion_o = o_start_q;
  assign request_channel_o  = o_req_q;
  assign sample_valid_o     = o_conv_q;
  assign sample_channel_o   = o_ch_q;
  assign sample_value_o     = o_smp_q;
  assign falling_edge_o     = o_fall_q;
  assign period_us_o        = o_period_q;
  assign monitor_high_o     = o_mon_q;

endmodule

`default_nettype wire
